>>> src/smts_pkg.sv
// Shared widths, types and constants for the strain median, tare and scale block.
package smts_pkg;

  // Field widths fixed by the sample and result formats
  localparam int SAMPLE_W  = 24;
  localparam int SCALE_W   = 24;
  localparam int FRAC_BITS = 8;
  localparam int DELTA_W   = SAMPLE_W + 1;
  localparam int NUM_W     = SAMPLE_W + FRAC_BITS;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [DELTA_W-1:0]  delta_t;

  // Scale after reset: 1110.0 counts per microstrain, 8 fraction bits
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd284160;

  // Largest strain magnitude that is reported
  localparam logic [SAMPLE_W-1:0] STRAIN_MAG = '1;
  localparam delta_t              STRAIN_MAX = 25'sd16777215;

  // Burst kinds
  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_ZERO    = 1'b1;

endpackage

>>> src/strain_median_tare_scaler.sv
// Load-cell burst median with per-channel tare and fixed-point strain scaling.
//
// Samples arrive on the in_valid/in_ready channel, one request per converter
// reading. Every BURST_LEN requests form one burst; kind and channel come from
// the burst's last request. When a burst is complete the block finds its median
// by a rank count with one shared comparator. A zero-capture burst stores the
// median as the channel zero and goes to the finish step. A measure burst
// subtracts the zero and runs a restoring divider, one quotient bit per cycle,
// giving strain = delta * 256 / scale, truncated toward zero and saturated.
// in_ready is low while a burst is being worked on and high while collecting.
// The result sits in an output register; collection of the next burst goes on
// while it waits, and the block only holds a new result when the receiver
// stalls with the previous one unread. The scale register is written through
// cfg_we/cfg_data. Reset empties the burst, clears all channel zeros, drops any
// pending result and restores the scale to 1110.0.
module strain_median_tare_scaler #(
  parameter int BURST_LEN    = 5,
  parameter int NUM_CHANNELS = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               kind,
  input  logic [1:0]                         channel,
  input  logic signed [smts_pkg::SAMPLE_W-1:0] sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               kind_res,
  output logic [1:0]                         channel_res,
  output logic signed [smts_pkg::SAMPLE_W-1:0] median_raw,
  output logic signed [smts_pkg::SAMPLE_W-1:0] tare_raw,
  output logic signed [smts_pkg::DELTA_W-1:0]  delta_raw,
  output logic signed [smts_pkg::DELTA_W-1:0]  strain,
  input  logic                               cfg_we,
  input  logic [smts_pkg::SCALE_W-1:0]       cfg_data
);
  import smts_pkg::*;

  localparam int IDX_W  = (BURST_LEN > 1) ? $clog2(BURST_LEN) : 1;
  localparam int CNT_W  = $clog2(BURST_LEN + 1);
  localparam int MID    = BURST_LEN / 2;
  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DCNT_W = $clog2(NUM_W);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(BURST_LEN - 1);
  localparam logic [DCNT_W-1:0] LAST_DIV = DCNT_W'(NUM_W - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SORT  = 3'd1;
  localparam logic [2:0] S_DELTA = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]         state;
  logic [SCALE_W-1:0] scale;
  sample_t            burst [BURST_LEN];
  sample_t            zero_tbl [NUM_CHANNELS];
  logic [IDX_W-1:0]   fill_idx;
  logic [IDX_W-1:0]   step_idx;
  logic [IDX_W-1:0]   pass_idx;
  sample_t            cand;
  sample_t            med;
  logic [CNT_W-1:0]   less_cnt;
  logic [CNT_W-1:0]   eq_cnt;
  logic               kind_q;
  logic [1:0]         ch_q;
  sample_t            zero_q;
  delta_t             delta_q;
  logic               neg;
  logic [SCALE_W-1:0] divisor;
  logic [SCALE_W-1:0] rem;
  logic [NUM_W-1:0]   num;
  logic [DCNT_W-1:0]  div_cnt;

  // Rank count: compare the rotating head against the held candidate
  logic             is_self;
  sample_t          cmp_val;
  logic             lt;
  logic             eq;
  logic [CNT_W-1:0] less_tot;
  logic [CNT_W-1:0] eq_tot;
  logic             hit;

  assign is_self  = (step_idx == '0);
  assign cmp_val  = is_self ? burst[0] : cand;
  assign lt       = !is_self && (burst[0] < cand);
  assign eq       = is_self || (burst[0] == cand);
  assign less_tot = (is_self ? '0 : less_cnt) + CNT_W'(lt);
  assign eq_tot   = (is_self ? '0 : eq_cnt) + CNT_W'(eq);
  assign hit      = (less_tot <= CNT_W'(MID)) &&
                    (({1'b0, less_tot} + {1'b0, eq_tot}) > (CNT_W + 1)'(MID));

  // Tare lookup and difference
  logic              ch_ok;
  logic [CH_W-1:0]   tbl_idx;
  sample_t           zero_sel;
  delta_t            diff;
  logic [DELTA_W-1:0] mag;

  assign ch_ok    = (32'(ch_q) < 32'(NUM_CHANNELS));
  assign tbl_idx  = CH_W'(ch_q);
  assign zero_sel = ch_ok ? zero_tbl[tbl_idx] : '0;
  assign diff     = $signed({med[SAMPLE_W-1], med}) - $signed({zero_sel[SAMPLE_W-1], zero_sel});
  assign mag      = diff[DELTA_W-1] ? DELTA_W'(-diff) : DELTA_W'(diff);

  // Restoring divider step
  logic [SCALE_W:0] rem_sh;
  logic [SCALE_W:0] rem_sub;
  logic             ge;

  assign rem_sh  = {rem, num[NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, divisor});
  assign rem_sub = rem_sh - {1'b0, divisor};

  // Saturate the quotient and apply the sign
  logic [SAMPLE_W-1:0] q_sat;
  delta_t              strain_val;

  assign q_sat      = (|num[NUM_W-1:SAMPLE_W]) ? STRAIN_MAG : num[SAMPLE_W-1:0];
  assign strain_val = neg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});

  assign in_ready = (state == S_IDLE);

  // Sequencer, burst store, tare table and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill_idx  <= '0;
      out_valid <= 1'b0;
      scale     <= SCALE_RESET;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        zero_tbl[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        scale <= cfg_data;
      end
      // drop the result once taken, unless the finish step replaces it
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            burst[fill_idx] <= sample;
            kind_q          <= kind;
            ch_q            <= channel;
            if (fill_idx == LAST_IDX) begin
              fill_idx <= '0;
              step_idx <= '0;
              pass_idx <= '0;
              state    <= S_SORT;
            end else begin
              fill_idx <= fill_idx + 1'b1;
            end
          end
        end
        S_SORT: begin
          if (is_self) begin
            cand <= burst[0];
          end
          less_cnt <= less_tot;
          eq_cnt   <= eq_tot;
          if (step_idx == LAST_IDX) begin
            if (hit) begin
              med <= cmp_val;
            end
            step_idx <= '0;
            if (pass_idx == LAST_IDX) begin
              state <= S_DELTA;
            end else begin
              pass_idx <= pass_idx + 1'b1;
            end
          end else begin
            // advance the ring by one sample
            for (int i = 0; i < BURST_LEN; i++) begin
              burst[i] <= burst[(i + 1) % BURST_LEN];
            end
            step_idx <= step_idx + 1'b1;
          end
        end
        S_DELTA: begin
          if (kind_q == KIND_ZERO) begin
            if (ch_ok) begin
              zero_tbl[tbl_idx] <= med;
            end
            zero_q  <= ch_ok ? med : '0;
            delta_q <= '0;
            num     <= '0;
            neg     <= 1'b0;
            state   <= S_DONE;
          end else begin
            zero_q  <= zero_sel;
            delta_q <= diff;
            neg     <= diff[DELTA_W-1];
            num     <= {mag[SAMPLE_W-1:0], FRAC_BITS'(0)};
            divisor <= (scale == '0) ? SCALE_W'(1) : scale;
            rem     <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= ge ? rem_sub[SCALE_W-1:0] : rem_sh[SCALE_W-1:0];
          num     <= {num[NUM_W-2:0], ge};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == LAST_DIV) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            kind_res    <= kind_q;
            channel_res <= ch_q;
            median_raw  <= med;
            tare_raw    <= zero_q;
            delta_raw   <= delta_q;
            strain      <= strain_val;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result appeared outside the finish step");

  a_capture_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind_res == KIND_ZERO) |-> (delta_raw == '0) && (strain == '0))
    else $error("zero capture result carries a difference or strain");

  a_strain_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (strain <= STRAIN_MAX) && (strain >= -STRAIN_MAX))
    else $error("strain outside saturation limit");

  a_delta_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind_res == KIND_MEASURE) |->
      delta_raw == ($signed({median_raw[SAMPLE_W-1], median_raw}) -
                    $signed({tare_raw[SAMPLE_W-1], tare_raw})))
    else $error("difference does not match median and zero");

  a_fill_parked: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> fill_idx == '0)
    else $error("burst fill index moved while a burst is in work");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the strain median, tare and scale block.
module testbench;
  import smts_pkg::*;

  localparam int      CLK_PERIOD     = 20;
  localparam int      BURST          = 5;
  localparam int      NUM_CH         = 4;
  localparam int      IDLE_PCT       = 23;
  localparam int      SETTLE_CYCLES  = 80;
  localparam int      HOLD_CYCLES    = 400;
  localparam longint  TIMEOUT_CYCLES = 400000;
  localparam sample_t SAMPLE_MAX     = 24'sh7FFFFF;
  localparam sample_t SAMPLE_MIN     = 24'sh800000;
  localparam logic [SCALE_W-1:0] SCALE_FULL = '1;

  typedef struct {
    logic       kind;
    logic [1:0] channel;
    sample_t    median;
    sample_t    zero;
    delta_t     delta;
    delta_t     strain;
  } reading_t;

  // Block ports
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic               kind      = 1'b0;
  logic [1:0]         channel   = '0;
  sample_t            sample    = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               kind_res;
  logic [1:0]         channel_res;
  sample_t            median_raw;
  sample_t            tare_raw;
  delta_t             delta_raw;
  delta_t             strain;
  logic               cfg_we    = 1'b0;
  logic [SCALE_W-1:0] cfg_data  = '0;

  // Predictor state
  logic [SCALE_W-1:0] scale_q8   = SCALE_RESET;
  sample_t            burst_buf [BURST];
  int                 burst_fill = 0;
  sample_t            zero_tbl  [NUM_CH] = '{default: '0};
  reading_t           pending_readings [$];

  // Run control and statistics
  bit tx_idle_en     = 1'b1;
  bit rx_idle_en     = 1'b1;
  int hold_req       = 0;
  int hold_ack       = 0;
  int hold_left      = 0;
  int errors         = 0;
  int samples_sent   = 0;
  int results_seen   = 0;
  int measure_bursts = 0;
  int zero_bursts    = 0;

  strain_median_tare_scaler #(
    .BURST_LEN   (BURST),
    .NUM_CHANNELS(NUM_CH)
  ) u_top (
    .clk, .rst,
    .in_valid, .in_ready, .kind, .channel, .sample,
    .out_valid, .out_ready, .kind_res, .channel_res,
    .median_raw, .tare_raw, .delta_raw, .strain,
    .cfg_we, .cfg_data
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Some tests failed");
    $finish;
  end

  // Collect one sample; on the last one of a burst, work out the reading it yields
  function automatic void predict_reading(input logic k, input logic [1:0] ch,
                                          input sample_t s);
    longint   sorted [BURST];
    longint   v, med, zero_v, diff, quot, divisor;
    int       j;
    reading_t r;
    burst_buf[burst_fill] = s;
    burst_fill++;
    if (burst_fill < BURST) return;
    burst_fill = 0;
    // Sort ascending and take the middle entry
    for (int i = 0; i < BURST; i++) sorted[i] = burst_buf[i];
    for (int i = 1; i < BURST; i++) begin
      v = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    med = sorted[BURST / 2];
    if (k == KIND_ZERO) begin
      zero_tbl[ch] = sample_t'(med);
      zero_v = med;
      diff = 0;
      quot = 0;
    end else begin
      zero_v = zero_tbl[ch];
      diff = med - zero_v;
      divisor = (scale_q8 == 0) ? 1 : longint'(scale_q8);
      quot = (diff * 256) / divisor;
      if (quot > longint'(STRAIN_MAX)) quot = longint'(STRAIN_MAX);
      if (quot < -longint'(STRAIN_MAX)) quot = -longint'(STRAIN_MAX);
    end
    r.kind    = k;
    r.channel = ch;
    r.median  = sample_t'(med);
    r.zero    = sample_t'(zero_v);
    r.delta   = delta_t'(diff);
    r.strain  = delta_t'(quot);
    pending_readings.push_back(r);
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic send_sample(input logic k, input logic [1:0] ch, input sample_t s);
    if (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    kind     <= k;
    channel  <= ch;
    sample   <= s;
    do @(posedge clk); while (!in_ready);
    predict_reading(k, ch, s);
    samples_sent++;
  endtask

  // Kind and channel only count on the last sample, so scramble the others
  task automatic send_burst(input logic k, input logic [1:0] ch, input sample_t vals [BURST]);
    for (int i = 0; i < BURST - 1; i++) send_sample(1'($urandom), 2'($urandom), vals[i]);
    send_sample(k, ch, vals[BURST-1]);
    if (k == KIND_ZERO) zero_bursts++;
    else measure_bursts++;
  endtask

  function automatic sample_t noisy_sample(input sample_t center);
    int off;
    case ($urandom_range(9))
      0, 1, 2: off = int'($urandom_range(8)) - 4;
      3, 4:    off = int'($urandom_range(65535)) - 32768;
      5, 6:    return sample_t'($urandom);
      7: begin
        case ($urandom_range(3))
          0:       return SAMPLE_MAX;
          1:       return SAMPLE_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: off = 0;
    endcase
    return sample_t'(center + off);
  endfunction

  // Bursts clustered around a random level, about one in four a zero capture
  task automatic send_random_bursts(input int count);
    sample_t    vals [BURST];
    sample_t    center;
    logic       k;
    logic [1:0] ch;
    repeat (count) begin
      center = sample_t'($urandom);
      for (int i = 0; i < BURST; i++) vals[i] = noisy_sample(center);
      k  = ($urandom_range(3) == 0) ? KIND_ZERO : KIND_MEASURE;
      ch = 2'($urandom);
      send_burst(k, ch, vals);
    end
  endtask

  // Drop valid, wait for every reading, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    scale_q8 = value;
  endtask

  task automatic test_mixed_order_median();
    send_burst(KIND_MEASURE, 2'd0,
               '{sample_t'(1), SAMPLE_MAX, sample_t'(-1), SAMPLE_MIN, sample_t'(0)});
  endtask

  task automatic test_zero_capture();
    send_burst(KIND_ZERO, 2'd1, '{default: SAMPLE_MIN});
    send_burst(KIND_MEASURE, 2'd1, '{default: SAMPLE_MAX});
  endtask

  task automatic test_scale_zero();
    settle();
    write_scale('0);
    send_burst(KIND_MEASURE, 2'd1, '{default: SAMPLE_MAX});
  endtask

  task automatic test_scale_one_negative();
    settle();
    write_scale(SCALE_W'(1));
    send_burst(KIND_MEASURE, 2'd2,
               '{SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, sample_t'(0), SAMPLE_MIN});
  endtask

  task automatic test_random_traffic(input logic [SCALE_W-1:0] value, input int bursts);
    settle();
    write_scale(value);
    send_random_bursts(bursts);
  endtask

  task automatic test_no_idle();
    settle();
    write_scale(SCALE_W'($urandom_range(256, SCALE_FULL)));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random_bursts(20);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Stall the receiver long enough that the block must hold off new requests
  task automatic test_backpressure();
    settle();
    write_scale(SCALE_W'($urandom_range(256, SCALE_FULL)));
    hold_req++;
    send_random_bursts(15);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Compare each accepted reading with the oldest prediction, then pick next ready
  always @(posedge clk) begin : rx_side
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_readings.size() == 0) begin
        $error("reading on channel %0d with none expected", channel_res);
        errors++;
      end else begin
        want = pending_readings.pop_front();
        check_field("kind_res", want.kind, kind_res);
        check_field("channel_res", want.channel, channel_res);
        check_field("median_raw", want.median, median_raw);
        check_field("tare_raw", want.zero, tare_raw);
        check_field("delta_raw", want.delta, delta_raw);
        check_field("strain", want.strain, strain);
      end
    end
    if (hold_req != hold_ack) begin
      hold_left = HOLD_CYCLES;
      hold_ack  = hold_req;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_idle_en) begin
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_mixed_order_median();
    test_zero_capture();
    test_scale_zero();
    test_scale_one_negative();
    test_random_traffic(SCALE_W'(256), 20);
    test_random_traffic(SCALE_FULL, 20);
    test_random_traffic(SCALE_RESET, 20);
    test_random_traffic(SCALE_W'($urandom_range(256, SCALE_FULL)), 20);
    test_random_traffic(SCALE_W'($urandom_range(255)), 20);
    test_no_idle();
    test_backpressure();
    settle();
    $display("Run covered %0d samples in %0d measure and %0d zero-capture bursts, %0d readings",
             samples_sent, measure_bursts, zero_bursts, results_seen);
    $display("Scales from 0 up to full range, random idling and a %0d-cycle receiver stall",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
